[hw/rtl/tpb_pkg.sv]
// Shared types and constants of the top-k pose buffer.
package tpb_pkg;
   localparam int DepthDefault = 16;
   localparam int MaxResults   = 16;

   localparam logic [2:0] StInserted   = 3'd0;
   localparam logic [2:0] StEvicted    = 3'd1;
   localparam logic [2:0] StReplaced   = 3'd2;
   localparam logic [2:0] StSuppressed = 3'd3;
   localparam logic [2:0] StDropped    = 3'd4;
   localparam logic [2:0] StListEntry  = 3'd5;
   localparam logic [2:0] StListEmpty  = 3'd6;

   localparam logic [1:0] RegKeepLimit = 2'd0;
   localparam logic [1:0] RegShift     = 2'd1;
   localparam logic [1:0] RegTurn      = 2'd2;

   localparam logic ReqAdd  = 1'b0;
   localparam logic ReqRead = 1'b1;

   typedef struct packed {
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic [15:0]        angle;
      logic [15:0]        scale;
      logic signed [23:0] score;
      logic [31:0]        id;
   } entry_type;
endpackage

[hw/rtl/topk_pose_buffer_with_nms.sv]
// Top level of the top-k pose buffer with non-maximum suppression.
// Add: accept, a scan for a matching pose, a decide step when no match is found, then, if the
//   candidate is kept, a slot search, a shift that moves entries one at a time and a final write,
//   then the result. Readout: a setup step, then one result per cycle while the receiver is ready.
// One item at a time: the input is ready again only after the last result has left.
// Reset clears count and state machine and sets the registers to their defaults; the entry store is not cleared.
module topk_pose_buffer_with_nms #(
   parameter int DEPTH = tpb_pkg::DepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic signed [19:0] req_pose_x,
   input  logic signed [19:0] req_pose_y,
   input  logic [15:0] req_pose_angle,
   input  logic [15:0] req_pose_scale,
   input  logic signed [23:0] req_cand_score,
   input  logic [31:0] req_cand_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic signed [19:0] rsp_out_x,
   output logic signed [19:0] rsp_out_y,
   output logic [15:0] rsp_out_angle,
   output logic [15:0] rsp_out_scale,
   output logic signed [23:0] rsp_out_score,
   output logic [31:0] rsp_out_id,
   output logic [31:0] rsp_suppressor_id,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_store_full,
   output logic signed [23:0] rsp_lowest_score,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   import tpb_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_DEC   = 7'b0000100,
      S_POS   = 7'b0001000,
      S_SHIFT = 7'b0010000,
      S_LIST  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   entry_type mem [DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [4:0]  limit_ff;
   logic [19:0] shift_ff;
   logic [15:0] turn_ff;
   entry_type cand_ff, cand_in;
   entry_type rd_ff;            // registered read of the store
   logic [CW-1:0] idx_ff, idx_in;   // scan / shift pointer
   logic [CW-1:0] hole_ff, hole_in; // slot freed by removal, or count when none
   logic [CW-1:0] pos_ff, pos_in;   // insertion slot
   logic [CW-1:0] rd_addr;
   logic rd_ok_ff, rd_ok_in;        // rd_ff holds slot idx_ff-1 ... see scan
   logic same;
   logic [CW-1:0] lim;
   logic we;
   logic [AW-1:0] wa;
   entry_type wd;
   logic [2:0]  st_ff, st_in;
   entry_type rep_ff, rep_in;
   logic [31:0] sup_ff, sup_in;
   logic lst_ff, lst_in;
   logic ov_ff, ov_in;          // output register holds an item
   logic signed [23:0] tail_ff; // score of the last stored slot

   // clamp the limit register to 1..DEPTH
   always_comb begin
      if (limit_ff == 5'd0) lim = CW'(1);
      else if (32'(limit_ff) > DEPTH) lim = CW'(DEPTH);
      else lim = CW'(limit_ff);
   end

   tpb_match u_match (.a(rd_ff), .b(cand_ff), .shift_thr(shift_ff), .turn_thr(turn_ff),
                      .same(same));

   // store port: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[rd_addr[AW-1:0]];
   end

   // Sequencer. Removal and insertion are done as one pass of moves:
   //   hole at h (removed slot, or count when none), new slot p.
   //   p<=h: move slots h-1 .. p up by one, write cand at p.
   //   p>h : move slots h+1 .. p down by one (p measured after removal).
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cand_in  = cand_ff;
      idx_in   = idx_ff;
      hole_in  = hole_ff;
      pos_in   = pos_ff;
      rd_ok_in = rd_ok_ff;
      st_in = st_ff; rep_in = rep_ff; sup_in = sup_ff; lst_in = lst_ff;
      ov_in = ov_ff;
      we = 1'b0; wa = '0; wd = cand_ff;
      rd_addr = idx_ff;
      req_ready = (state_ff == S_IDLE) && !ov_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_valid && req_ready) begin
               cand_in = '{req_pose_x, req_pose_y, req_pose_angle, req_pose_scale,
                           req_cand_score, req_cand_id};
               idx_in = CW'(1);
               rd_ok_in = 1'b1;
               if (req_type == ReqRead) begin
                  if (count_ff == '0) begin
                     st_in = StListEmpty; rep_in = '0; sup_in = '0; lst_in = 1'b1;
                     ov_in = 1'b1;
                  end else state_in = S_LIST;
               end else if (req_cand_score <= 0) begin
                  st_in = StDropped; rep_in = cand_in; sup_in = '0; lst_in = 1'b1;
                  ov_in = 1'b1;
               end else begin
                  idx_in = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_LIST: begin
            // rd_ff holds slot idx_ff-1
            if (!ov_ff || rsp_ready) begin
               st_in = StListEntry; rep_in = rd_ff; sup_in = '0;
               lst_in = (idx_ff == count_ff) || (32'(idx_ff) == MaxResults);
               ov_in = 1'b1;
               rd_addr = idx_ff;
               idx_in = idx_ff + CW'(1);
               if (lst_in) state_in = S_IDLE;
            end else rd_addr = idx_ff - CW'(1);
         end
         S_SCAN: begin
            // idx_ff = slot being read this cycle; rd_ok says rd_ff is slot idx_ff-1
            rd_addr = idx_ff;
            idx_in = idx_ff + CW'(1);
            if (rd_ok_ff && idx_ff != '0 && same) begin
               hole_in = idx_ff - CW'(1);
               if (cand_ff.score > rd_ff.score) begin
                  st_in = StReplaced; rep_in = rd_ff; sup_in = cand_ff.id;
                  count_in = count_ff - CW'(1);
                  idx_in = '0; state_in = S_POS;
                  rd_addr = '0;
               end else begin
                  st_in = StSuppressed; rep_in = cand_ff; sup_in = rd_ff.id;
                  lst_in = 1'b1; state_in = S_OUT;
               end
            end else if (idx_ff == count_ff) begin
               state_in = S_DEC;
               rd_addr = count_ff - CW'(1);
            end
         end
         S_DEC: begin
            // rd_ff holds the lowest entry (when count>0)
            idx_in = '0;
            rd_addr = '0;
            if (count_ff < lim) begin
               st_in = StInserted; rep_in = '0; sup_in = '0;
               hole_in = count_ff; count_in = count_ff; state_in = S_POS;
            end else if (cand_ff.score <= rd_ff.score) begin
               st_in = StEvicted; rep_in = cand_ff; sup_in = '0;
               lst_in = 1'b1; state_in = S_OUT;
            end else begin
               st_in = StEvicted; rep_in = rd_ff; sup_in = '0;
               hole_in = count_ff - CW'(1); count_in = count_ff - CW'(1);
               state_in = S_POS;
            end
         end
         S_POS: begin
            // find p over entries excluding the hole; rd_ff = slot idx_ff-1 whenever idx_ff is nonzero
            rd_addr = idx_ff;
            idx_in = idx_ff + CW'(1);
            if (idx_ff != '0 && (idx_ff - CW'(1)) != hole_ff
                && rd_ff.score < cand_ff.score) begin
               pos_in = (idx_ff - CW'(1) > hole_ff) ? idx_ff - CW'(2) : idx_ff - CW'(1);
               state_in = S_SHIFT;
            end else if (idx_ff == count_ff + ((hole_ff < count_ff) ? CW'(1) : CW'(0))) begin
               pos_in = count_ff;
               state_in = S_SHIFT;
            end
            if (state_in == S_SHIFT) begin
               idx_in = (pos_in <= hole_ff) ? hole_ff : hole_ff + CW'(1);
               rd_addr = (pos_in <= hole_ff) ? hole_ff - CW'(1) : hole_ff + CW'(1);
               rd_ok_in = 1'b0;
            end
         end
         S_SHIFT: begin
            // idx_ff = destination slot; rd_ff holds its source once rd_ok set
            if (pos_ff <= hole_ff) begin
               if (idx_ff == pos_ff) begin
                  we = 1'b1; wa = AW'(pos_ff); wd = cand_ff;
                  count_in = count_ff + CW'(1); lst_in = 1'b1; state_in = S_OUT;
               end else if (!rd_ok_ff) begin
                  rd_ok_in = 1'b1; rd_addr = idx_ff - CW'(1);
               end else begin
                  we = 1'b1; wa = AW'(idx_ff); wd = rd_ff;
                  idx_in = idx_ff - CW'(1); rd_addr = idx_ff - CW'(3);
                  rd_ok_in = 1'b0;
               end
            end else begin
               // idx_ff = source slot, destination idx_ff-1
               if (idx_ff == pos_ff + CW'(1)) begin
                  we = 1'b1; wa = AW'(pos_ff); wd = cand_ff;
                  count_in = count_ff + CW'(1); lst_in = 1'b1; state_in = S_OUT;
               end else if (!rd_ok_ff) begin
                  rd_ok_in = 1'b1; rd_addr = idx_ff;
               end else begin
                  we = 1'b1; wa = AW'(idx_ff - CW'(1)); wd = rd_ff;
                  idx_in = idx_ff + CW'(1); rd_addr = idx_ff + CW'(1);
                  rd_ok_in = 1'b0;
               end
            end
         end
         S_OUT: begin
            rd_addr = '0;
            if (!ov_ff) begin
               ov_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
         limit_ff <= 5'd16;
         shift_ff <= 20'd16;
         turn_ff  <= 16'd182;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
         rd_ok_ff <= rd_ok_in;
         if (csr_we) begin
            unique case (csr_index)
               RegKeepLimit: if (count_ff == '0) limit_ff <= csr_wdata[4:0];
               RegShift:     shift_ff <= csr_wdata;
               RegTurn:      turn_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in; idx_ff <= idx_in; hole_ff <= hole_in; pos_ff <= pos_in;
      st_ff <= st_in; rep_ff <= rep_in; sup_ff <= sup_in; lst_ff <= lst_in;
   end

   // lowest stored score: during a shift the count excludes the new entry, so the
   // final tail slot is count_ff; each slot is written once, so catch that write
   always_ff @(posedge clock) begin
      if (we && wa == AW'(count_ff)) tail_ff <= wd.score;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_status        = st_ff;
   assign rsp_out_x         = rep_ff.x;
   assign rsp_out_y         = rep_ff.y;
   assign rsp_out_angle     = rep_ff.angle;
   assign rsp_out_scale     = rep_ff.scale;
   assign rsp_out_score     = rep_ff.score;
   assign rsp_out_id        = rep_ff.id;
   assign rsp_suppressor_id = sup_ff;
   assign rsp_entry_count   = 5'(count_ff);
   assign rsp_store_full    = (count_ff >= lim);
   assign rsp_lowest_score  = (count_ff == '0) ? 24'sd0 : tail_ff;
   assign rsp_last          = lst_ff;
endmodule

[hw/rtl/tpb_match.sv]
// Pose match compare between one stored entry and the candidate.
module tpb_match (
   input  tpb_pkg::entry_type  a,
   input  tpb_pkg::entry_type  b,
   input  logic [19:0]         shift_thr,
   input  logic [15:0]         turn_thr,
   output logic                same
);
   import tpb_pkg::*;
   logic signed [20:0] dx, dy;
   logic [20:0] adx, ady;
   logic [15:0] d;
   logic [16:0] mag;
   always_comb begin
      dx  = 21'(a.x) - 21'(b.x);
      dy  = 21'(a.y) - 21'(b.y);
      adx = dx[20] ? 21'(-dx) : 21'(dx);
      ady = dy[20] ? 21'(-dy) : 21'(dy);
      d   = a.angle - b.angle;
      mag = (d <= 16'd32768) ? {1'b0, d} : (17'h10000 - {1'b0, d});
      same = (adx < {1'b0, shift_thr}) && (ady < {1'b0, shift_thr})
             && (mag < {1'b0, turn_thr}) && (a.scale == b.scale);
   end
endmodule

[sim/topk_pose_buffer_with_nms_checker.sv]
// Checker for the top-k pose buffer: predicts each item's results and compares them.
`timescale 1ns / 1ps
module topk_pose_buffer_with_nms_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_type,
   input  logic signed [19:0] req_pose_x,
   input  logic signed [19:0] req_pose_y,
   input  logic [15:0]        req_pose_angle,
   input  logic [15:0]        req_pose_scale,
   input  logic signed [23:0] req_cand_score,
   input  logic [31:0]        req_cand_id,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_status,
   input  logic signed [19:0] rsp_out_x,
   input  logic signed [19:0] rsp_out_y,
   input  logic [15:0]        rsp_out_angle,
   input  logic [15:0]        rsp_out_scale,
   input  logic signed [23:0] rsp_out_score,
   input  logic [31:0]        rsp_out_id,
   input  logic [31:0]        rsp_suppressor_id,
   input  logic [4:0]         rsp_entry_count,
   input  logic               rsp_store_full,
   input  logic signed [23:0] rsp_lowest_score,
   input  logic               rsp_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 checked
);
   import tpb_pkg::*;

   typedef struct packed {
      logic [2:0]         status;
      entry_type          ent;
      logic [31:0]        supp;
      logic [4:0]         count;
      logic               full;
      logic signed [23:0] lowest;
      logic               last;
   } outcome_type;

   entry_type   ranked[DepthDefault];
   int          held;
   logic [4:0]  limit_reg;
   logic [19:0] shift_reg;
   logic [15:0] turn_reg;
   outcome_type outcome_q[$];

   function automatic int eff_limit();
      int l;
      l = limit_reg;
      if (l < 1) l = 1;
      if (l > DepthDefault) l = DepthDefault;
      return l;
   endfunction

   function automatic bit poses_close(entry_type a, entry_type b);
      int dx, dy, mag;
      logic [15:0] d;
      dx = int'(a.x) - int'(b.x);
      dy = int'(a.y) - int'(b.y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d = a.angle - b.angle;
      mag = (d <= 16'd32768) ? int'(d) : 65536 - int'(d);
      return dx < int'(shift_reg) && dy < int'(shift_reg) &&
             mag < int'(turn_reg) && a.scale == b.scale;
   endfunction

   // Insert behind every entry of equal or higher score.
   task automatic place(entry_type e);
      int p;
      p = 0;
      while (p < held && ranked[p].score >= e.score) p++;
      for (int j = held; j > p; j--) ranked[j] = ranked[j-1];
      ranked[p] = e;
      held++;
   endtask

   task automatic drop_at(int i);
      for (int j = i; j < held - 1; j++) ranked[j] = ranked[j+1];
      held--;
   endtask

   task automatic push_outcome(logic [2:0] st, entry_type e, logic [31:0] supp, bit last);
      outcome_type o;
      o.status = st;
      o.ent    = e;
      o.supp   = supp;
      o.count  = 5'(held);
      o.full   = held >= eff_limit();
      o.lowest = held != 0 ? ranked[held-1].score : '0;
      o.last   = last;
      outcome_q.insert(outcome_q.size(), o);
   endtask

   task automatic predict_item();
      entry_type c, old;
      int n, lim, p;
      bit found;
      lim = eff_limit();
      c = '{req_pose_x, req_pose_y, req_pose_angle, req_pose_scale, req_cand_score,
            req_cand_id};
      found = 0;
      if (req_type == ReqRead) begin
         n = held > MaxResults ? MaxResults : held;
         if (n == 0) push_outcome(StListEmpty, '0, '0, 1);
         for (int i = 0; i < n; i++) push_outcome(StListEntry, ranked[i], '0, i + 1 == n);
      end else if (c.score <= 0) begin
         push_outcome(StDropped, c, '0, 1);
      end else begin
         // Stop at the first stored entry with the same pose, highest first.
         for (int i = 0; i < held && !found; i++) begin
            if (poses_close(ranked[i], c)) begin
               found = 1;
               if (c.score > ranked[i].score) begin
                  old = ranked[i];
                  drop_at(i);
                  place(c);
                  push_outcome(StReplaced, old, c.id, 1);
               end else begin
                  push_outcome(StSuppressed, c, ranked[i].id, 1);
               end
            end
         end
         if (!found) begin
            if (held < lim) begin
               place(c);
               push_outcome(StInserted, '0, '0, 1);
            end else begin
               p = 0;
               while (p < held && ranked[p].score >= c.score) p++;
               if (p >= held) begin
                  push_outcome(StEvicted, c, '0, 1);
               end else begin
                  old = ranked[held-1];
                  held--;
                  place(c);
                  push_outcome(StEvicted, old, '0, 1);
               end
            end
         end
      end
   endtask

   function automatic string show(outcome_type o);
      return $sformatf("st=%0d id=%h sc=%0d sup=%h n=%0d f=%0d lo=%0d l=%0d",
                       o.status, o.ent.id, o.ent.score, o.supp, o.count, o.full,
                       o.lowest, o.last);
   endfunction

   task automatic report(string what, outcome_type got, outcome_type want);
      $display("MISMATCH %s: got %s | want %s", what, show(got), show(want));
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      held       = 0;
   end

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         held      = 0;
         limit_reg = 5'd16;
         shift_reg = 20'd16;
         turn_reg  = 16'd182;
         outcome_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               RegKeepLimit: if (held == 0) limit_reg = csr_wdata[4:0];
               RegShift:     shift_reg = csr_wdata;
               RegTurn:      turn_reg = csr_wdata[15:0];
               default:      ;
            endcase
         end
         if (req_valid && req_ready) predict_item();
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, '{rsp_out_x, rsp_out_y, rsp_out_angle, rsp_out_scale,
                    rsp_out_score, rsp_out_id}, rsp_suppressor_id, rsp_entry_count,
                    rsp_store_full, rsp_lowest_score, rsp_last};
            if (outcome_q.size() == 0) begin
               report("unexpected result", got, '0);
            end else begin
               want = outcome_q.pop_front();
               checked++;
               if (got.status !== want.status) report("status", got, want);
               else if (got.ent !== want.ent) report("entry", got, want);
               else if (got.supp !== want.supp) report("suppressor", got, want);
               else if (got.count !== want.count) report("count", got, want);
               else if (got.full !== want.full) report("full", got, want);
               else if (got.lowest !== want.lowest) report("lowest", got, want);
               else if (got.last !== want.last) report("last", got, want);
            end
         end
      end
      pending = outcome_q.size();
   end
endmodule

[sim/topk_pose_buffer_with_nms_tb.sv]
// Testbench top for the top-k pose buffer: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module topk_pose_buffer_with_nms_tb;
   import tpb_pkg::*;

   localparam int CycleLimit = 600000;
   localparam int StallSpan  = 400;

   logic               clock;
   logic               reset;
   logic               req_valid, req_ready, req_type;
   logic signed [19:0] req_pose_x, req_pose_y;
   logic [15:0]        req_pose_angle, req_pose_scale;
   logic signed [23:0] req_cand_score;
   logic [31:0]        req_cand_id;
   logic               rsp_valid, rsp_ready;
   logic [2:0]         rsp_status;
   logic signed [19:0] rsp_out_x, rsp_out_y;
   logic [15:0]        rsp_out_angle, rsp_out_scale;
   logic signed [23:0] rsp_out_score;
   logic [31:0]        rsp_out_id, rsp_suppressor_id;
   logic [4:0]         rsp_entry_count;
   logic               rsp_store_full;
   logic signed [23:0] rsp_lowest_score;
   logic               rsp_last;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [19:0]        csr_wdata;

   int fail_count, pending, checked;
   int cycles;
   int adds_sent, reads_sent;
   bit calm;          // suppress random idling on both sides
   bit stall_toggle;  // flip to start one long receiver hold-off
   entry_type base_pose[6];

   topk_pose_buffer_with_nms dut (.*);

   topk_pose_buffer_with_nms_checker checker_i (.*);

   initial begin
      clock          = 0;
      reset          = 1;
      req_valid      = 0;
      req_type       = ReqAdd;
      req_pose_x     = '0;
      req_pose_y     = '0;
      req_pose_angle = '0;
      req_pose_scale = '0;
      req_cand_score = '0;
      req_cand_id    = '0;
      rsp_ready      = 0;
      csr_we         = 0;
      csr_index      = RegKeepLimit;
      csr_wdata      = '0;
      calm           = 0;
      stall_toggle   = 0;
      cycles         = 0;
   end

   always #4 clock = ~clock;

   // Bound the run; a hang ends here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles, %0d results still pending", cycles, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      int hold_left;
      bit seen_toggle;
      hold_left   = 0;
      seen_toggle = 0;
      forever begin
         @(negedge clock);
         if (stall_toggle != seen_toggle) begin
            seen_toggle = stall_toggle;
            hold_left   = StallSpan;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
         end
      end
   end

   // Offer one item and hold it until accepted; idle first at random.
   task automatic send(logic typ, logic signed [19:0] x, logic signed [19:0] y,
                       logic [15:0] ang, logic [15:0] scl, logic signed [23:0] score,
                       logic [31:0] id);
      if (!calm && $urandom_range(0, 99) < 33) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1;
      req_type       <= typ;
      req_pose_x     <= x;
      req_pose_y     <= y;
      req_pose_angle <= ang;
      req_pose_scale <= scl;
      req_cand_score <= score;
      req_cand_id    <= id;
      do @(posedge clock); while (!req_ready);
      if (typ == ReqRead) reads_sent++;
      else adds_sent++;
   endtask

   task automatic add(logic signed [19:0] x, logic signed [19:0] y, logic [15:0] ang,
                      logic [15:0] scl, logic signed [23:0] score, logic [31:0] id);
      send(ReqAdd, x, y, ang, scl, score, id);
   endtask

   task automatic readout();
      send(ReqRead, 20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom),
           24'($urandom), $urandom);
   endtask

   // Stop offering and wait until every expected result is back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
   endtask

   // Write a register once the block is idle; allow the scan and shift to settle.
   task automatic write_reg(logic [1:0] idx, logic [19:0] value);
      drain();
      repeat (48) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
   endtask

   // Random add or readout, mostly near a small set of poses so matches happen.
   task automatic random_item();
      int kind, jit, k;
      logic signed [23:0] score;
      entry_type b;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         readout();
      end else if (kind < 16) begin
         add(20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
             $urandom);
      end else begin
         k   = $urandom_range(0, 5);
         b   = base_pose[k];
         jit = $urandom_range(0, 40);
         case ($urandom_range(0, 9))
            0:       score = -$signed(24'($urandom_range(0, 3)));
            1, 2:    score = 24'(100 * $urandom_range(1, 3));
            default: score = 24'($urandom_range(1, 5000));
         endcase
         add(b.x + 20'($urandom_range(0, 2 * jit)) - 20'(jit),
             b.y + 20'($urandom_range(0, 2 * jit)) - 20'(jit),
             b.angle + 16'($urandom_range(0, 600)) - 16'd300,
             ($urandom_range(0, 9) == 0) ? b.scale + 16'd1 : b.scale,
             score, $urandom);
      end
   endtask

   initial begin
      int shift_set[6];
      int turn_set[6];
      adds_sent  = 0;
      reads_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Empty store: limit zero acts as one, then the top, then the run's value.
      write_reg(RegKeepLimit, 20'd0);
      readout();
      add(20'sd1, 20'sd1, 16'd0, 16'd0, 24'sd0, 32'h1);
      add(-20'sd524288, -20'sd524288, 16'd0, 16'd0, -24'sd8388608, 32'h0);
      write_reg(RegKeepLimit, 20'd31);
      write_reg(RegKeepLimit, 20'($urandom_range(3, 16)));

      // Directed: extremes, wrap of the angle, suppression, replacement, ties.
      add(20'sd524287, -20'sd524288, 16'hFFFF, 16'hFFFF, 24'sd8388607, 32'hFFFF_FFFF);
      add(20'sd0, 20'sd0, 16'd0, 16'd0, 24'sd1, 32'h0);
      add(20'sd524282, -20'sd524280, 16'd10, 16'hFFFF, 24'sd5, 32'hA5A5_0001);
      add(20'sd3, -20'sd3, 16'd100, 16'd0, 24'sd50, 32'hA5A5_0002);
      add(20'sd1000, 20'sd1000, 16'd0, 16'd7, 24'sd50, 32'hA5A5_0003);
      add(20'sd2000, 20'sd2000, 16'd0, 16'd7, 24'sd50, 32'hA5A5_0004);
      add(20'sd1000, 20'sd1000, 16'd182, 16'd7, 24'sd60, 32'hA5A5_0005);
      add(20'sd1015, 20'sd985, 16'd181, 16'd7, 24'sd60, 32'hA5A5_0006);
      add(20'sd1016, 20'sd1000, 16'd0, 16'd7, 24'sd40, 32'hA5A5_0007);
      add(20'sd2000, 20'sd2000, 16'd0, 16'd8, 24'sd50, 32'hA5A5_0008);
      readout();
      for (int i = 0; i < 10; i++)
         add(20'(5000 * i), 20'sd77, 16'd0, 16'd1, 24'(30 - 3 * i), 32'hB000_0000 + i);
      add(20'sd99999, 20'sd0, 16'd0, 16'd2, 24'sd1, 32'hC000_0001);
      readout();

      // Limit writes from here on find a non-empty store; index 3 decodes to nothing.
      write_reg(RegKeepLimit, 20'd1);
      write_reg(2'd3, 20'hFFFFF);

      shift_set = '{16, 0, 1048575, $urandom_range(8, 200), 16, $urandom_range(1, 64)};
      turn_set  = '{182, 0, 32768, $urandom_range(100, 3000), 182, $urandom_range(1, 500)};
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(RegShift, 20'(shift_set[ph]));
         write_reg(RegTurn, 20'(turn_set[ph]));
         if (ph > 0) write_reg(RegKeepLimit, 20'($urandom_range(0, 31)));
         for (int k = 0; k < 6; k++)
            base_pose[k] = '{20'($urandom), 20'($urandom), 16'($urandom),
                             16'($urandom_range(0, 3)), 24'd0, 32'd0};
         calm = (ph == 4);
         for (int n = 0; n < 60; n++) begin
            if (ph == 2 && n == 10) stall_toggle = ~stall_toggle;
            if (n == 30 || $urandom_range(0, 99) < 2) drain();
            random_item();
         end
         calm = 0;
      end

      drain();
      repeat (60) @(posedge clock);
      $display("Covered %0d adds and %0d readouts over six threshold settings",
               adds_sent, reads_sent);
      $display("%0d results checked, %0d mismatches", checked, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
hw/rtl/tpb_pkg.sv
hw/rtl/tpb_match.sv
hw/rtl/topk_pose_buffer_with_nms.sv
sim/topk_pose_buffer_with_nms_checker.sv
sim/topk_pose_buffer_with_nms_tb.sv
